/* sv/palette_reverse_lookup_assert.svh */
// Assertion macros for the palette reverse lookup checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef PALETTE_REVERSE_LOOKUP_ASSERT_SVH
`define PALETTE_REVERSE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define PLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/plr_pkg.sv */
// Shared types and constants for the palette reverse lookup.
// No dependencies.
package plr_pkg;

    localparam int unsigned PLR_DEPTH_DEF = 256;
    localparam int unsigned COUNT_W       = 9;
    localparam int unsigned CHAN_W        = 16;
    localparam int unsigned INDEX_W       = 8;
    localparam int unsigned PIX_W         = 3 * CHAN_W;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [INDEX_W-1:0] entry_index;
        logic [CHAN_W-1:0] red_value;
        logic [CHAN_W-1:0] green_value;
        logic [CHAN_W-1:0] blue_value;
    } plr_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] match_index;
        logic               found;
    } plr_out_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } plr_state_t;

endpackage

/* sv/palette_reverse_lookup.sv */
// Palette reverse lookup: top level with palette memory and scan sequencer. Depends on plr_pkg.
// Load beat: written at the accepting edge, no result, busy stays low; one load a cycle while idle.
// Lookup beat: entries are read and compared in order until the first hit, result registered;
// scans N = min(palette_count, PALETTE_DEPTH) entries, none if N is 0. Next beat taken with the result.
// One entry per cycle through the single read port; the receiver cannot stall.
// Reset clears control and palette_count; palette contents stay undefined.
module palette_reverse_lookup
    import plr_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = PLR_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plr_in_t             cmd,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    output logic                result_valid,
    output plr_out_t            result
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);
    localparam int unsigned LW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

    logic [PIX_W-1:0]   palette_mem [PALETTE_DEPTH];

    plr_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [LW-1:0]      iss_reg, iss_next;
    logic               cmp_valid_reg;
    logic               cmp_last_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic [PIX_W-1:0]   rd_data_reg;
    logic               res_valid_reg, res_valid_next;
    plr_out_t           res_reg, res_next;

    logic [LW-1:0]      limit;
    logic               accept;
    logic               is_lookup;
    logic               load_ok;
    logic [AW+7:0]      wr_addr_wide;
    logic [AW+7:0]      hit_idx_wide;
    logic               hit;
    logic               issue;
    logic               finish;

    assign limit = (LW'(count_reg) > LW'(PALETTE_DEPTH)) ? LW'(PALETTE_DEPTH)
                                                          : LW'(count_reg);
    assign accept       = start && !busy;
    assign is_lookup    = (cmd.mode == MODE_LOOKUP);
    assign wr_addr_wide = {{AW{1'b0}}, cmd.entry_index};
    assign load_ok      = accept && !is_lookup
                          && (LW'(cmd.entry_index) < LW'(PALETTE_DEPTH));
    assign hit          = cmp_valid_reg && (rd_data_reg == pix_reg);
    assign hit_idx_wide = {8'b0, cmp_idx_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_lookup && (limit != '0))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        finish = 1'b0;
        issue  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                finish = 1'b0;
                issue  = 1'b0;
            end
            ST_SCAN:
            begin
                finish = cmp_valid_reg && (hit || cmp_last_reg);
                issue  = !finish && (iss_reg < limit);
            end
            default:
            begin
                finish = 1'b0;
                issue  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        iss_next = iss_reg;
        if (accept && is_lookup)
            iss_next = '0;
        else if (issue)
            iss_next = iss_reg + LW'(1);
    end

    always_comb
    begin
        res_valid_next = finish || (accept && is_lookup && (limit == '0));
        res_next       = res_reg;
        if (res_valid_next)
        begin
            res_next.found       = finish && hit;
            res_next.match_index = (finish && hit) ? hit_idx_wide[7:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            cmp_valid_reg <= issue;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept && is_lookup)
            pix_reg <= {cmd.red_value, cmd.green_value, cmd.blue_value};
        if (issue)
        begin
            cmp_idx_reg  <= iss_reg[AW-1:0];
            cmp_last_reg <= ((iss_reg + LW'(1)) == limit);
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_ok)
            palette_mem[wr_addr_wide[AW-1:0]] <=
                {cmd.red_value, cmd.green_value, cmd.blue_value};
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            rd_data_reg <= palette_mem[iss_reg[AW-1:0]];
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* sv/plr_checker.sv */
// Port-level checker for the palette reverse lookup, bound to the top level.
// Depends on plr_pkg and palette_reverse_lookup_assert.svh.
`include "palette_reverse_lookup_assert.svh"

module plr_checker
    import plr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  plr_in_t             cmd,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                result_valid,
    input  plr_out_t            result
);

    `PLR_ASSERT_NOW(a_miss_index_zero, result_valid && !result.found,
        result.match_index == '0, "miss beat with non-zero index")
    `PLR_ASSERT_NOW(a_done_with_result, $fell(busy), result_valid,
        "scan ended without a result beat")
    `PLR_ASSERT_NEXT(a_load_silent, start && !busy && (cmd.mode == MODE_LOAD),
        !result_valid && !busy, "load beat produced a result or stalled")
    `PLR_ASSERT_NEXT(a_lookup_progress, start && !busy && (cmd.mode == MODE_LOOKUP),
        busy || result_valid, "lookup beat neither scanning nor answered")

endmodule

bind palette_reverse_lookup plr_checker u_plr_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for palette_reverse_lookup: palette loads, colour lookups and
// palette_count settings, with every lookup answer checked against a shadow palette.
// Depends on plr_pkg and the palette_reverse_lookup RTL.
module tb;
    import plr_pkg::*;

    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned BEATS_PER_PHASE = 55;
    localparam int unsigned PHASES          = 9;
    localparam logic [COUNT_W-1:0] PHASE_COUNTS [PHASES] =
        '{9'd1, 9'd40, 9'd256, 9'd511, 9'd0, 9'd3, 9'd255, 9'd300, 9'd128};

    class palette_shadow;
        logic [PIX_W-1:0]   entries [PLR_DEPTH_DEF];
        logic [COUNT_W-1:0] searched = '0;
        plr_out_t           answers_due [$];
        int unsigned        errors = 0;

        function void set_count(input logic [COUNT_W-1:0] value);
            searched = value;
        endfunction

        function void record_beat(input plr_in_t beat);
            plr_out_t    answer;
            int unsigned limit;
            logic [PIX_W-1:0] pixel;
            pixel = {beat.red_value, beat.green_value, beat.blue_value};
            if (beat.mode == MODE_LOAD)
            begin
                entries[beat.entry_index] = pixel;
                return;
            end
            answer = '0;
            limit = (searched > PLR_DEPTH_DEF) ? PLR_DEPTH_DEF : searched;
            for (int j = 0; j < limit; j++)
            begin
                if (entries[j] == pixel)
                begin
                    answer.match_index = INDEX_W'(j);
                    answer.found = 1'b1;
                    break;
                end
            end
            answers_due.push_back(answer);
        endfunction

        function void check_answer(input plr_out_t got);
            plr_out_t want;
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual index %0d found %0b",
                         $time, got.match_index, got.found);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0b actual %0b",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.match_index !== want.match_index)
            begin
                $display("%0t: match_index mismatch, expected %0d actual %0d",
                         $time, want.match_index, got.match_index);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    plr_in_t            cmd;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic               result_valid;
    plr_out_t           result;

    palette_shadow      shadow = new();
    logic [PIX_W-1:0]   palette_img [PLR_DEPTH_DEF];
    bit                 loaded [PLR_DEPTH_DEF];
    logic [PIX_W-1:0]   color_pool [4];
    int unsigned        beats_sent = 0;
    int unsigned        stall_cycles = 0;

    palette_reverse_lookup DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                shadow.set_count(cfg_wr_data);
            if (result_valid)
                shadow.check_answer(result);
            if (start && !busy)
                shadow.record_beat(cmd);
            if (cfg_wr_en || result_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic logic [PIX_W-1:0] make_color();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            return color_pool[$urandom_range(3)];
        return raw[PIX_W-1:0];
    endfunction

    task automatic send_beat(input plr_in_t beat);
        int unsigned idle_pct;
        idle_pct = (beats_sent < 250) ? 18 : ((beats_sent < 500) ? 71 : 0);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [PIX_W-1:0] color);
        plr_in_t beat;
        beat.mode = MODE_LOAD;
        beat.entry_index = idx;
        {beat.red_value, beat.green_value, beat.blue_value} = color;
        send_beat(beat);
        palette_img[idx] = color;
        loaded[idx] = 1'b1;
    endtask

    task automatic look_up(input logic [PIX_W-1:0] color);
        plr_in_t beat;
        beat.mode = MODE_LOOKUP;
        beat.entry_index = INDEX_W'($urandom);
        {beat.red_value, beat.green_value, beat.blue_value} = color;
        send_beat(beat);
    endtask

    // hold start low until every answer is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (shadow.answers_due.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_palette_count(input logic [COUNT_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] value);
        int unsigned      limit;
        int unsigned      pick;
        int unsigned      j;
        logic [PIX_W-1:0] color;
        set_palette_count(value);
        limit = (value > PLR_DEPTH_DEF) ? PLR_DEPTH_DEF : value;
        // fill every searched entry before the first lookup
        for (int i = 0; i < limit; i++)
            if (!loaded[i])
                load_entry(INDEX_W'(i), make_color());
        repeat (BEATS_PER_PHASE)
        begin
            if ($urandom_range(99) < 40)
                load_entry(INDEX_W'($urandom), make_color());
            else
            begin
                pick = $urandom_range(99);
                if (pick < 50 && limit > 0)
                    color = palette_img[$urandom_range(limit - 1)];
                else if (pick < 65)
                begin
                    j = $urandom_range(PLR_DEPTH_DEF - 1);
                    color = loaded[j] ? palette_img[j] : make_color();
                end
                else if (pick < 85 && limit > 0)
                    color = palette_img[$urandom_range(limit - 1)]
                            ^ (48'h1 << $urandom_range(PIX_W - 1));
                else
                    color = make_color();
                look_up(color);
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        color_pool[0] = '0;
        color_pool[1] = '1;
        color_pool[2] = PIX_W'({$urandom, $urandom});
        color_pool[3] = PIX_W'({$urandom, $urandom});
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        look_up('0);
        look_up('1);
        load_entry(8'd0, '0);
        load_entry(8'd1, '1);
        load_entry(8'd2, 48'hFFFF_0000_0000);
        load_entry(8'd3, 48'h0000_FFFF_0000);
        load_entry(8'd4, 48'h0000_0000_FFFF);
        load_entry(8'd5, '1);
        load_entry(8'd128, 48'hAAAA_5555_AAAA);
        load_entry(8'd255, 48'h1234_5678_9ABC);
        set_palette_count(9'd6);
        look_up('0);
        look_up('1);
        look_up(48'hFFFF_0000_0000);
        look_up(48'h0000_FFFF_0000);
        look_up(48'h0000_0000_FFFF);
        look_up(48'hFFFF_FFFF_FFFE);
        look_up(48'h1234_5678_9ABC);

        for (int p = 0; p < PHASES; p++)
            run_phase(PHASE_COUNTS[p]);
        drain();

        if (shadow.errors == 0 && shadow.answers_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

/* palette_reverse_lookup.f */
+incdir+sv
sv/plr_pkg.sv
sv/palette_reverse_lookup.sv
sv/plr_checker.sv
tb/tb.sv
